// ----- rtl/ilp_pkg.sv -----
// Shared types and constants for the integer literal parser.
package ilp_pkg;

	localparam int VALUE_W = 64;
	// Head room for acc * 16 + 15 in signed form.
	localparam int WIDE_W = VALUE_W + 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic signed [VALUE_W-1:0] SAT_POS_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic signed [VALUE_W-1:0] SAT_NEG_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_PLUS       = 8'h2B;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_LOW_X      = 8'h78;
	localparam logic [7:0] CH_UP_X       = 8'h58;
	localparam logic [7:0] CH_LOW_O      = 8'h6F;
	localparam logic [7:0] CH_UP_O       = 8'h4F;
	localparam logic [7:0] CH_LOW_B      = 8'h62;
	localparam logic [7:0] CH_UP_B       = 8'h42;
	localparam logic [7:0] CH_LOW_A      = 8'h61;
	localparam logic [7:0] CH_LOW_F      = 8'h66;
	localparam logic [7:0] CH_UP_A       = 8'h41;
	localparam logic [7:0] CH_UP_F       = 8'h46;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_HASH       = 8'h23;
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] LOWER_HEX_BIAS = 8'h57;
	localparam logic [7:0] UPPER_HEX_BIAS = 8'h37;

	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_HEX = 2'd1,
		RX_OCT = 2'd2,
		RX_BIN = 2'd3
	} radix_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_INVALID  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		PH_START  = 4'b0001,
		PH_SIGNED = 4'b0010,
		PH_ZERO   = 4'b0100,
		PH_DIGITS = 4'b1000
	} phase_t;

	// Classified byte as handed from the front to the back.
	typedef struct packed {
		logic       underscore;
		logic       minus;
		logic       plus;
		logic       zero;
		logic       pfx_hex;
		logic       pfx_oct;
		logic       pfx_bin;
		logic       term;
		logic       dec_digit;
		logic       hex_letter;
		logic [3:0] dval;
		logic       last;
	} item_t;

endpackage

// ----- rtl/ilp_front.sv -----
// Front end: classifies one text byte into character flags and digit value.
module ilp_front
	import ilp_pkg::*;
(
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output item_t      item
);

	logic [7:0] dec_off;
	logic [7:0] low_off;
	logic [7:0] up_off;
	logic       is_low_hex;
	logic       is_up_hex;

	assign dec_off = text_byte - CH_ZERO;
	assign low_off = text_byte - LOWER_HEX_BIAS;
	assign up_off  = text_byte - UPPER_HEX_BIAS;
	assign is_low_hex = (text_byte >= CH_LOW_A) && (text_byte <= CH_LOW_F);
	assign is_up_hex  = (text_byte >= CH_UP_A) && (text_byte <= CH_UP_F);

	always_comb begin
		item.underscore = (text_byte == CH_UNDERSCORE);
		item.minus      = (text_byte == CH_MINUS);
		item.plus       = (text_byte == CH_PLUS);
		item.zero       = (text_byte == CH_ZERO);
		item.pfx_hex    = (text_byte == CH_LOW_X) || (text_byte == CH_UP_X);
		item.pfx_oct    = (text_byte == CH_LOW_O) || (text_byte == CH_UP_O);
		item.pfx_bin    = (text_byte == CH_LOW_B) || (text_byte == CH_UP_B);
		item.term       = (text_byte == CH_SPACE) || (text_byte == CH_TAB)
			|| (text_byte == CH_NEWLINE) || (text_byte == CH_HASH)
			|| (text_byte == CH_NUL);
		item.dec_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
		item.hex_letter = is_low_hex || is_up_hex;
		item.last       = end_of_text;
		if (is_low_hex) begin
			item.dval = low_off[3:0];
		end else if (is_up_hex) begin
			item.dval = up_off[3:0];
		end else begin
			item.dval = dec_off[3:0];
		end
	end

endmodule

// ----- rtl/ilp_queue.sv -----
// Short queue of classified bytes between the front and the back.
module ilp_queue
	import ilp_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign push_ready = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

// ----- rtl/ilp_back.sv -----
// Back end: literal scanner, signed shift-add accumulator and result register.
module ilp_back
	import ilp_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  item_t                      item,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VALUE_W-1:0] number_value,
	output logic [1:0]                 parse_status,
	output logic                       byte_not_used
);

	phase_t                    phase_q;
	logic                      neg_q;
	radix_t                    radix_q;
	logic signed [VALUE_W-1:0] acc_q;
	logic                      ovf_q;
	logic                      us_q;
	logic                      seen_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	status_t                   status_q;
	logic                      notused_q;

	phase_t                    ph_n;
	logic                      neg_n;
	radix_t                    rad_n;
	logic signed [VALUE_W-1:0] acc_n;
	logic                      ovf_n;
	logic                      us_n;
	logic                      seen_n;

	logic                      step;
	logic                      do_body;
	logic                      ended;
	logic                      fixed_emit;
	status_t                   fixed_st;
	logic                      emit;
	logic signed [VALUE_W-1:0] e_val;
	status_t                   e_st;
	logic                      e_nu;

	logic                      digit_ok;
	logic signed [WIDE_W-1:0]  acc_w;
	logic signed [WIDE_W-1:0]  sd_w;
	logic signed [WIDE_W-1:0]  scaled_w;
	logic signed [WIDE_W-1:0]  sum_w;
	logic                      fits;

	assign item_ready = !out_valid_q || out_ready;
	assign step = item_valid && item_ready;

	// Digit legality in the current radix.
	always_comb begin
		unique case (radix_q)
			RX_DEC: digit_ok = item.dec_digit;
			RX_HEX: digit_ok = item.dec_digit || item.hex_letter;
			RX_OCT: digit_ok = item.dec_digit && !item.dval[3];
			RX_BIN: digit_ok = item.dec_digit && (item.dval[3:1] == 3'd0);
			default: digit_ok = 1'b0;
		endcase
	end

	// Signed accumulate: acc * radix +/- digit, overflow when it leaves 64 bits.
	always_comb begin
		acc_w = WIDE_W'(acc_q);
		sd_w  = neg_q ? -$signed({{(WIDE_W-4){1'b0}}, item.dval})
		              :  $signed({{(WIDE_W-4){1'b0}}, item.dval});
		unique case (radix_q)
			RX_DEC: scaled_w = (acc_w <<< 3) + (acc_w <<< 1);
			RX_HEX: scaled_w = acc_w <<< 4;
			RX_OCT: scaled_w = acc_w <<< 3;
			RX_BIN: scaled_w = acc_w <<< 1;
			default: scaled_w = acc_w;
		endcase
		sum_w = scaled_w + sd_w;
		fits = (sum_w[WIDE_W-1:VALUE_W-1] == '0) || (sum_w[WIDE_W-1:VALUE_W-1] == '1);
	end

	always_comb begin
		ph_n       = phase_q;
		neg_n      = neg_q;
		rad_n      = radix_q;
		acc_n      = acc_q;
		ovf_n      = ovf_q;
		us_n       = us_q;
		seen_n     = seen_q;
		do_body    = 1'b0;
		ended      = 1'b0;
		fixed_emit = 1'b0;
		fixed_st   = ST_OK;

		unique case (phase_q)
			PH_ZERO: begin
				ph_n = PH_DIGITS;
				priority if (item.pfx_hex) begin
					rad_n = RX_HEX;
				end else if (item.pfx_oct) begin
					rad_n = RX_OCT;
				end else if (item.pfx_bin) begin
					rad_n = RX_BIN;
				end else if (item.term) begin
					fixed_emit = 1'b1;
				end else begin
					fixed_emit = 1'b1;
					fixed_st   = ST_INVALID;
				end
			end
			PH_DIGITS: begin
				do_body = 1'b1;
			end
			PH_SIGNED: begin
				if (item.zero) begin
					ph_n = PH_ZERO;
				end else begin
					do_body = 1'b1;
				end
			end
			default: begin
				priority if (item.minus) begin
					neg_n = 1'b1;
					ph_n  = PH_SIGNED;
				end else if (item.plus) begin
					ph_n = PH_SIGNED;
				end else if (item.zero) begin
					ph_n = PH_ZERO;
				end else begin
					do_body = 1'b1;
				end
			end
		endcase

		if (do_body) begin
			ph_n = PH_DIGITS;
			if (item.underscore) begin
				if (!seen_q || us_q) begin
					ended = 1'b1;
				end else begin
					us_n = 1'b1;
				end
			end else if (digit_ok) begin
				seen_n = 1'b1;
				us_n   = 1'b0;
				if (!ovf_q) begin
					if (fits) begin
						acc_n = sum_w[VALUE_W-1:0];
					end else begin
						ovf_n = 1'b1;
						acc_n = neg_q ? SAT_NEG_VALUE : SAT_POS_VALUE;
					end
				end
			end else begin
				ended = 1'b1;
			end
		end

		emit  = 1'b1;
		e_val = acc_n;
		e_st  = ovf_n ? ST_OVERFLOW : ST_OK;
		e_nu  = 1'b0;
		priority if (fixed_emit) begin
			e_val = '0;
			e_st  = fixed_st;
			e_nu  = 1'b1;
		end else if (ended) begin
			e_nu = 1'b1;
		end else if (item.last) begin
			// lone zero at end of text is zero, not invalid
			if (ph_n == PH_ZERO) begin
				e_val = '0;
				e_st  = ST_OK;
			end
		end else begin
			emit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			radix_q <= RX_DEC;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			us_q    <= 1'b0;
			seen_q  <= 1'b0;
		end else if (step) begin
			if (emit) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				radix_q <= RX_DEC;
				acc_q   <= '0;
				ovf_q   <= 1'b0;
				us_q    <= 1'b0;
				seen_q  <= 1'b0;
			end else begin
				phase_q <= ph_n;
				neg_q   <= neg_n;
				radix_q <= rad_n;
				acc_q   <= acc_n;
				ovf_q   <= ovf_n;
				us_q    <= us_n;
				seen_q  <= seen_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result register on each emitted transfer.
	always_ff @(posedge clk) begin
		if (step && emit) begin
			value_q   <= e_val;
			status_q  <= e_st;
			notused_q <= e_nu;
		end
	end

	assign out_valid     = out_valid_q;
	assign number_value  = value_q;
	assign parse_status  = status_q;
	assign byte_not_used = notused_q;

endmodule

// ----- rtl/integer_literal_parser_core.sv -----
// Top level of the integer literal parser: front classifier, queue, back scanner.
//
// Streams one ASCII byte per transfer and returns one result per integer
// literal: a signed 64-bit value saturated on overflow, a status (ok,
// overflow, invalid) and a flag that tells whether the byte that ended the
// literal belongs to the next token. An optional sign and a 0x/0o/0b prefix
// are accepted; single underscores between digits are skipped. The block
// sustains one byte per clock cycle while the output is not stalled, a rate
// set by the back end's combinational shift-add and range check on the 64-bit
// accumulator. A byte passes through a two-entry queue and then the result
// register before its result shows at the output.
module integer_literal_parser_core
	import ilp_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 text_byte,
	input  logic                       end_of_text,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [VALUE_W-1:0] number_value,
	output logic [1:0]                 parse_status,
	output logic                       byte_not_used
);

	item_t front_item;
	item_t back_item;
	logic  q_valid;
	logic  q_ready;

	ilp_front u_front (
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.item        (front_item)
	);

	ilp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_item  (front_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_item   (back_item)
	);

	ilp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (q_valid),
		.item_ready    (q_ready),
		.item          (back_item),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.number_value  (number_value),
		.parse_status  (parse_status),
		.byte_not_used (byte_not_used)
	);

endmodule

// ----- tb/sv/integer_literal_parser_core_test.sv -----
// Testbench for integer_literal_parser_core: streamed literals checked against a behavioral predictor.
module integer_literal_parser_core_test;
	import ilp_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 1050;
	localparam int QUIET_FROM  = 880;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_LIMIT = 20000;
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic               not_used;
	} literal_result_t;

	class literal_scoreboard;
		phase_t             phase;
		logic               neg;
		radix_t             radix;
		logic [VALUE_W-1:0] mag;
		logic               ovf;
		logic               prev_us;
		logic               seen;
		literal_result_t    pending_results[$];
		int                 errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			phase = PH_START;
			neg = 1'b0;
			radix = RX_DEC;
			mag = '0;
			ovf = 1'b0;
			prev_us = 1'b0;
			seen = 1'b0;
		endfunction

		task report(string what);
			$display("%0t mismatch: %s", $realtime, what);
			errors++;
		endtask

		function logic [VALUE_W-1:0] radix_num();
			case (radix)
				RX_HEX: return VALUE_W'(16);
				RX_OCT: return VALUE_W'(8);
				RX_BIN: return VALUE_W'(2);
				default: return VALUE_W'(10);
			endcase
		endfunction

		function int digit_value(logic [7:0] c);
			int d;
			d = -1;
			if (c >= CH_ZERO && c <= CH_NINE)
				d = c - CH_ZERO;
			else if (radix == RX_HEX && c >= CH_LOW_A && c <= CH_LOW_F)
				d = c - CH_LOW_A + 10;
			else if (radix == RX_HEX && c >= CH_UP_A && c <= CH_UP_F)
				d = c - CH_UP_A + 10;
			if (d >= 0 && d >= int'(radix_num()))
				d = -1;
			return d;
		endfunction

		function void add_digit(int d);
			logic [VALUE_W-1:0] limit;
			logic [VALUE_W-1:0] r;
			logic [VALUE_W-1:0] dd;
			limit = neg ? $unsigned(SAT_NEG_VALUE) : $unsigned(SAT_POS_VALUE);
			r = radix_num();
			dd = VALUE_W'(d);
			seen = 1'b1;
			prev_us = 1'b0;
			if (ovf)
				return;
			// saturate once the next shift-add would leave the signed range
			if (mag > (limit - dd) / r) begin
				ovf = 1'b1;
				mag = limit;
			end else begin
				mag = mag * r + dd;
			end
		endfunction

		// Returns 1 when the byte ends the literal.
		function bit body_byte(logic [7:0] c);
			int d;
			phase = PH_DIGITS;
			if (c == CH_UNDERSCORE) begin
				if (!seen || prev_us)
					return 1'b1;
				prev_us = 1'b1;
				return 1'b0;
			end
			d = digit_value(c);
			if (d < 0)
				return 1'b1;
			add_digit(d);
			return 1'b0;
		endfunction

		function void queue_result(logic [VALUE_W-1:0] v, status_t st, logic nu);
			literal_result_t r;
			r.value = v;
			r.status = st;
			r.not_used = nu;
			pending_results.push_back(r);
			clear();
		endfunction

		function void finish_number(logic nu);
			logic [VALUE_W-1:0] v;
			v = neg ? 64'd0 - mag : mag;
			if (ovf)
				queue_result(v, ST_OVERFLOW, nu);
			else
				queue_result(v, ST_OK, nu);
		endfunction

		function void note_input(logic [7:0] c, logic last);
			bit ended;
			ended = 1'b0;
			case (phase)
				PH_ZERO: begin
					if (c == CH_LOW_X || c == CH_UP_X) begin
						radix = RX_HEX;
					end else if (c == CH_LOW_O || c == CH_UP_O) begin
						radix = RX_OCT;
					end else if (c == CH_LOW_B || c == CH_UP_B) begin
						radix = RX_BIN;
					end else if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE ||
							c == CH_HASH || c == CH_NUL) begin
						queue_result('0, ST_OK, 1'b1);
						return;
					end else begin
						queue_result('0, ST_INVALID, 1'b1);
						return;
					end
					phase = PH_DIGITS;
				end
				PH_DIGITS: ended = body_byte(c);
				PH_SIGNED: begin
					if (c == CH_ZERO)
						phase = PH_ZERO;
					else
						ended = body_byte(c);
				end
				default: begin
					if (c == CH_MINUS) begin
						neg = 1'b1;
						phase = PH_SIGNED;
					end else if (c == CH_PLUS) begin
						phase = PH_SIGNED;
					end else if (c == CH_ZERO) begin
						phase = PH_ZERO;
					end else begin
						ended = body_byte(c);
					end
				end
			endcase
			if (ended) begin
				finish_number(1'b1);
				return;
			end
			if (last) begin
				if (phase == PH_ZERO)
					queue_result('0, ST_OK, 1'b0);
				else
					finish_number(1'b0);
			end
		endfunction

		task check_result(logic [VALUE_W-1:0] v, logic [1:0] st, logic nu);
			literal_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result with none pending: value=%0d status=%0d not_used=%0b",
					$signed(v), st, nu));
				return;
			end
			want = pending_results.pop_front();
			if (v !== want.value)
				report($sformatf("number_value %0d, want %0d", $signed(v), $signed(want.value)));
			if (st !== want.status)
				report($sformatf("parse_status %0d, want %0d", st, want.status));
			if (nu !== want.not_used)
				report($sformatf("byte_not_used %0b, want %0b", nu, want.not_used));
		endtask
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [7:0]                text_byte = '0;
	logic                      end_of_text = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [VALUE_W-1:0] number_value;
	logic [1:0]                parse_status;
	logic                      byte_not_used;

	literal_scoreboard sb = new();

	bit         tx_gaps = 1'b1;
	bit         rx_gaps = 1'b1;
	bit         hold_request = 1'b0;
	int         items_sent = 0;
	logic [7:0] lit_bytes[$];
	bit         lit_eot;
	string      messy_chars = "+-0_xXoObB9aFg #";

	integer_literal_parser_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.text_byte    (text_byte),
		.end_of_text  (end_of_text),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.number_value (number_value),
		.parse_status (parse_status),
		.byte_not_used(byte_not_used)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(number_value, parse_status, byte_not_used);
			if (in_valid && in_ready)
				sb.note_input(text_byte, end_of_text);
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(logic [7:0] b, logic eot);
		if (tx_gaps && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		text_byte <= b;
		end_of_text <= eot;
		do
			@(posedge clk);
		while (!in_ready);
		items_sent++;
	endtask

	task automatic send_text(string s, bit eot_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eot_last && i == s.len() - 1);
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10)
			return 8'(CH_ZERO + d);
		return 8'(($urandom_range(0, 1) ? CH_UP_A : CH_LOW_A) + d - 10);
	endfunction

	// Fill lit_bytes with one literal: mostly well formed, some noise and broken text.
	task automatic build_literal();
		int                 kind;
		radix_t             rx;
		logic [VALUE_W-1:0] r;
		logic [VALUE_W-1:0] v;
		logic [7:0]         digits[$];
		lit_bytes.delete();
		lit_eot = 1'b0;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			lit_bytes.push_back(8'($urandom_range(0, 255)));
			lit_eot = ($urandom_range(0, 15) == 0);
			return;
		end
		if (kind < 16) begin
			repeat ($urandom_range(1, 5))
				lit_bytes.push_back(messy_chars[$urandom_range(0, messy_chars.len() - 1)]);
			lit_eot = ($urandom_range(0, 9) == 0);
			return;
		end
		case ($urandom_range(0, 2))
			0: lit_bytes.push_back(CH_MINUS);
			1: lit_bytes.push_back(CH_PLUS);
			default: ;
		endcase
		rx = radix_t'($urandom_range(0, 3));
		case (rx)
			RX_HEX: begin
				r = 16;
				lit_bytes.push_back(CH_ZERO);
				lit_bytes.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LOW_X);
			end
			RX_OCT: begin
				r = 8;
				lit_bytes.push_back(CH_ZERO);
				lit_bytes.push_back($urandom_range(0, 1) ? CH_UP_O : CH_LOW_O);
			end
			RX_BIN: begin
				r = 2;
				lit_bytes.push_back(CH_ZERO);
				lit_bytes.push_back($urandom_range(0, 1) ? CH_UP_B : CH_LOW_B);
			end
			default: r = 10;
		endcase
		if ($urandom_range(0, 7) == 0) begin
			// values at the edges of the signed range
			case ($urandom_range(0, 4))
				0: v = $unsigned(SAT_POS_VALUE);
				1: v = $unsigned(SAT_NEG_VALUE);
				2: v = $unsigned(SAT_NEG_VALUE) + 1;
				3: v = '1;
				default: v = {$urandom, $urandom};
			endcase
		end else if ($urandom_range(0, 9) == 0) begin
			v = {$urandom, $urandom} >> $urandom_range(0, 63);
		end else begin
			v = VALUE_W'($urandom_range(0, 99999));
		end
		do begin
			digits.push_front(digit_char(int'(v % r)));
			v = v / r;
		end while (v != 0);
		if (rx != RX_DEC && $urandom_range(0, 5) == 0)
			digits.push_front(CH_ZERO);
		foreach (digits[i]) begin
			if (i > 0 && $urandom_range(0, 7) == 0) begin
				lit_bytes.push_back(CH_UNDERSCORE);
				if ($urandom_range(0, 4) == 0)
					lit_bytes.push_back(CH_UNDERSCORE);
			end
			lit_bytes.push_back(digits[i]);
		end
		if ($urandom_range(0, 11) == 0)
			lit_bytes.push_back(CH_UNDERSCORE);
		if ($urandom_range(0, 5) == 0) begin
			lit_eot = 1'b1;
		end else begin
			case ($urandom_range(0, 7))
				0: lit_bytes.push_back(CH_SPACE);
				1: lit_bytes.push_back(CH_TAB);
				2: lit_bytes.push_back(CH_NEWLINE);
				3: lit_bytes.push_back(CH_HASH);
				4: lit_bytes.push_back(CH_NUL);
				5: lit_bytes.push_back(8'h2C);
				default: lit_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
			lit_eot = ($urandom_range(0, 7) == 0);
		end
	endtask

	initial begin
		bit hold_done;
		int drain;
		hold_done = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero then terminator, zero then other byte, zero and prefix at end of text
		send_text("0 ", 1'b0);
		send_text("0z", 1'b0);
		send_text("0", 1'b1);
		send_text("0b", 1'b1);
		// leading, doubled and trailing underscore
		send_text("_", 1'b0);
		send_text("1__", 1'b0);
		send_text("-7_", 1'b1);
		// sign with no digits, octal and hex bodies
		send_text("+x", 1'b0);
		send_text("0o7#", 1'b0);
		send_text("0XfF", 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_byte(8'hFF, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_request = 1'b1;
				hold_done = 1'b1;
			end
			if (items_sent >= QUIET_FROM) begin
				tx_gaps = 1'b0;
				rx_gaps = 1'b0;
			end
			build_literal();
			foreach (lit_bytes[i])
				send_byte(lit_bytes[i], lit_eot && i == lit_bytes.size() - 1);
		end
		in_valid <= 1'b0;

		drain = 0;
		while (sb.pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.pending_results.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
